>>> rtl/aktm_pkg.sv
package aktm_pkg;

  localparam int NumRounds = 10;

  localparam logic [0:0] RegBlockHigh = 1'b0;
  localparam logic [0:0] RegBlockLow  = 1'b1;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] tried_key_high;
    logic [63:0] tried_key_low;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_beat_t;

  // Data handed from one round cell to the next.
  typedef struct packed {
    logic vld;
    blk_t st;
    blk_t rk;
    blk_t key;
  } link_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] y;
    unique case (x)
      8'h00: y=8'h63; 8'h01: y=8'h7c; 8'h02: y=8'h77; 8'h03: y=8'h7b;
      8'h04: y=8'hf2; 8'h05: y=8'h6b; 8'h06: y=8'h6f; 8'h07: y=8'hc5;
      8'h08: y=8'h30; 8'h09: y=8'h01; 8'h0a: y=8'h67; 8'h0b: y=8'h2b;
      8'h0c: y=8'hfe; 8'h0d: y=8'hd7; 8'h0e: y=8'hab; 8'h0f: y=8'h76;
      8'h10: y=8'hca; 8'h11: y=8'h82; 8'h12: y=8'hc9; 8'h13: y=8'h7d;
      8'h14: y=8'hfa; 8'h15: y=8'h59; 8'h16: y=8'h47; 8'h17: y=8'hf0;
      8'h18: y=8'had; 8'h19: y=8'hd4; 8'h1a: y=8'ha2; 8'h1b: y=8'haf;
      8'h1c: y=8'h9c; 8'h1d: y=8'ha4; 8'h1e: y=8'h72; 8'h1f: y=8'hc0;
      8'h20: y=8'hb7; 8'h21: y=8'hfd; 8'h22: y=8'h93; 8'h23: y=8'h26;
      8'h24: y=8'h36; 8'h25: y=8'h3f; 8'h26: y=8'hf7; 8'h27: y=8'hcc;
      8'h28: y=8'h34; 8'h29: y=8'ha5; 8'h2a: y=8'he5; 8'h2b: y=8'hf1;
      8'h2c: y=8'h71; 8'h2d: y=8'hd8; 8'h2e: y=8'h31; 8'h2f: y=8'h15;
      8'h30: y=8'h04; 8'h31: y=8'hc7; 8'h32: y=8'h23; 8'h33: y=8'hc3;
      8'h34: y=8'h18; 8'h35: y=8'h96; 8'h36: y=8'h05; 8'h37: y=8'h9a;
      8'h38: y=8'h07; 8'h39: y=8'h12; 8'h3a: y=8'h80; 8'h3b: y=8'he2;
      8'h3c: y=8'heb; 8'h3d: y=8'h27; 8'h3e: y=8'hb2; 8'h3f: y=8'h75;
      8'h40: y=8'h09; 8'h41: y=8'h83; 8'h42: y=8'h2c; 8'h43: y=8'h1a;
      8'h44: y=8'h1b; 8'h45: y=8'h6e; 8'h46: y=8'h5a; 8'h47: y=8'ha0;
      8'h48: y=8'h52; 8'h49: y=8'h3b; 8'h4a: y=8'hd6; 8'h4b: y=8'hb3;
      8'h4c: y=8'h29; 8'h4d: y=8'he3; 8'h4e: y=8'h2f; 8'h4f: y=8'h84;
      8'h50: y=8'h53; 8'h51: y=8'hd1; 8'h52: y=8'h00; 8'h53: y=8'hed;
      8'h54: y=8'h20; 8'h55: y=8'hfc; 8'h56: y=8'hb1; 8'h57: y=8'h5b;
      8'h58: y=8'h6a; 8'h59: y=8'hcb; 8'h5a: y=8'hbe; 8'h5b: y=8'h39;
      8'h5c: y=8'h4a; 8'h5d: y=8'h4c; 8'h5e: y=8'h58; 8'h5f: y=8'hcf;
      8'h60: y=8'hd0; 8'h61: y=8'hef; 8'h62: y=8'haa; 8'h63: y=8'hfb;
      8'h64: y=8'h43; 8'h65: y=8'h4d; 8'h66: y=8'h33; 8'h67: y=8'h85;
      8'h68: y=8'h45; 8'h69: y=8'hf9; 8'h6a: y=8'h02; 8'h6b: y=8'h7f;
      8'h6c: y=8'h50; 8'h6d: y=8'h3c; 8'h6e: y=8'h9f; 8'h6f: y=8'ha8;
      8'h70: y=8'h51; 8'h71: y=8'ha3; 8'h72: y=8'h40; 8'h73: y=8'h8f;
      8'h74: y=8'h92; 8'h75: y=8'h9d; 8'h76: y=8'h38; 8'h77: y=8'hf5;
      8'h78: y=8'hbc; 8'h79: y=8'hb6; 8'h7a: y=8'hda; 8'h7b: y=8'h21;
      8'h7c: y=8'h10; 8'h7d: y=8'hff; 8'h7e: y=8'hf3; 8'h7f: y=8'hd2;
      8'h80: y=8'hcd; 8'h81: y=8'h0c; 8'h82: y=8'h13; 8'h83: y=8'hec;
      8'h84: y=8'h5f; 8'h85: y=8'h97; 8'h86: y=8'h44; 8'h87: y=8'h17;
      8'h88: y=8'hc4; 8'h89: y=8'ha7; 8'h8a: y=8'h7e; 8'h8b: y=8'h3d;
      8'h8c: y=8'h64; 8'h8d: y=8'h5d; 8'h8e: y=8'h19; 8'h8f: y=8'h73;
      8'h90: y=8'h60; 8'h91: y=8'h81; 8'h92: y=8'h4f; 8'h93: y=8'hdc;
      8'h94: y=8'h22; 8'h95: y=8'h2a; 8'h96: y=8'h90; 8'h97: y=8'h88;
      8'h98: y=8'h46; 8'h99: y=8'hee; 8'h9a: y=8'hb8; 8'h9b: y=8'h14;
      8'h9c: y=8'hde; 8'h9d: y=8'h5e; 8'h9e: y=8'h0b; 8'h9f: y=8'hdb;
      8'ha0: y=8'he0; 8'ha1: y=8'h32; 8'ha2: y=8'h3a; 8'ha3: y=8'h0a;
      8'ha4: y=8'h49; 8'ha5: y=8'h06; 8'ha6: y=8'h24; 8'ha7: y=8'h5c;
      8'ha8: y=8'hc2; 8'ha9: y=8'hd3; 8'haa: y=8'hac; 8'hab: y=8'h62;
      8'hac: y=8'h91; 8'had: y=8'h95; 8'hae: y=8'he4; 8'haf: y=8'h79;
      8'hb0: y=8'he7; 8'hb1: y=8'hc8; 8'hb2: y=8'h37; 8'hb3: y=8'h6d;
      8'hb4: y=8'h8d; 8'hb5: y=8'hd5; 8'hb6: y=8'h4e; 8'hb7: y=8'ha9;
      8'hb8: y=8'h6c; 8'hb9: y=8'h56; 8'hba: y=8'hf4; 8'hbb: y=8'hea;
      8'hbc: y=8'h65; 8'hbd: y=8'h7a; 8'hbe: y=8'hae; 8'hbf: y=8'h08;
      8'hc0: y=8'hba; 8'hc1: y=8'h78; 8'hc2: y=8'h25; 8'hc3: y=8'h2e;
      8'hc4: y=8'h1c; 8'hc5: y=8'ha6; 8'hc6: y=8'hb4; 8'hc7: y=8'hc6;
      8'hc8: y=8'he8; 8'hc9: y=8'hdd; 8'hca: y=8'h74; 8'hcb: y=8'h1f;
      8'hcc: y=8'h4b; 8'hcd: y=8'hbd; 8'hce: y=8'h8b; 8'hcf: y=8'h8a;
      8'hd0: y=8'h70; 8'hd1: y=8'h3e; 8'hd2: y=8'hb5; 8'hd3: y=8'h66;
      8'hd4: y=8'h48; 8'hd5: y=8'h03; 8'hd6: y=8'hf6; 8'hd7: y=8'h0e;
      8'hd8: y=8'h61; 8'hd9: y=8'h35; 8'hda: y=8'h57; 8'hdb: y=8'hb9;
      8'hdc: y=8'h86; 8'hdd: y=8'hc1; 8'hde: y=8'h1d; 8'hdf: y=8'h9e;
      8'he0: y=8'he1; 8'he1: y=8'hf8; 8'he2: y=8'h98; 8'he3: y=8'h11;
      8'he4: y=8'h69; 8'he5: y=8'hd9; 8'he6: y=8'h8e; 8'he7: y=8'h94;
      8'he8: y=8'h9b; 8'he9: y=8'h1e; 8'hea: y=8'h87; 8'heb: y=8'he9;
      8'hec: y=8'hce; 8'hed: y=8'h55; 8'hee: y=8'h28; 8'hef: y=8'hdf;
      8'hf0: y=8'h8c; 8'hf1: y=8'ha1; 8'hf2: y=8'h89; 8'hf3: y=8'h0d;
      8'hf4: y=8'hbf; 8'hf5: y=8'he6; 8'hf6: y=8'h42; 8'hf7: y=8'h68;
      8'hf8: y=8'h41; 8'hf9: y=8'h99; 8'hfa: y=8'h2d; 8'hfb: y=8'h0f;
      8'hfc: y=8'hb0; 8'hfd: y=8'h54; 8'hfe: y=8'hbb; 8'hff: y=8'h16;
      default: y=8'h00;
    endcase
    return y;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] y;
    unique case (rnd)
      4'd1: y = 8'h01; 4'd2: y = 8'h02; 4'd3: y = 8'h04; 4'd4: y = 8'h08;
      4'd5: y = 8'h10; 4'd6: y = 8'h20; 4'd7: y = 8'h40; 4'd8: y = 8'h80;
      4'd9: y = 8'h1b; 4'd10: y = 8'h36;
      default: y = 8'h00;
    endcase
    return y;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of a 128-bit word, byte 0 most significant.
  function automatic logic [7:0] byte_of(input blk_t v, input int n);
    return v[127 - 8*n -: 8];
  endfunction

endpackage

>>> rtl/aktm_stream_if.sv
interface aktm_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/aktm_round_cell.sv
module aktm_round_cell
  import aktm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [3:0] rnd,
  input  link_t      lnk_i,
  output link_t      lnk_r
);

  blk_t       sr;
  blk_t       mc;
  blk_t       rk_nxt;
  logic [7:0] t0, t1, t2, t3, all;
  logic [31:0] tw;
  link_t      lnk_nxt;

  // SubBytes + ShiftRows; byte r + 4c from byte r + 4((c + r) & 3)
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8*(r + 4*c) -: 8] = sbox(byte_of(lnk_i.st, r + 4*((c + r) % 4)));
      end
    end
  end

  always_comb begin
    mc = sr;
    t0 = '0; t1 = '0; t2 = '0; t3 = '0; all = '0;
    if (rnd != 4'(NumRounds)) begin
      for (int c = 0; c < 4; c++) begin
        t0 = byte_of(sr, 4*c);
        t1 = byte_of(sr, 4*c + 1);
        t2 = byte_of(sr, 4*c + 2);
        t3 = byte_of(sr, 4*c + 3);
        all = t0 ^ t1 ^ t2 ^ t3;
        mc[127 - 8*(4*c)     -: 8] = t0 ^ all ^ xtime(t0 ^ t1);
        mc[127 - 8*(4*c + 1) -: 8] = t1 ^ all ^ xtime(t1 ^ t2);
        mc[127 - 8*(4*c + 2) -: 8] = t2 ^ all ^ xtime(t2 ^ t3);
        mc[127 - 8*(4*c + 3) -: 8] = t3 ^ all ^ xtime(t3 ^ t0);
      end
    end
  end

  // Next round key from the previous one.
  always_comb begin
    tw = {sbox(lnk_i.rk[23:16]) ^ rcon(rnd), sbox(lnk_i.rk[15:8]),
          sbox(lnk_i.rk[7:0]), sbox(lnk_i.rk[31:24])};
    rk_nxt[127:96] = lnk_i.rk[127:96] ^ tw;
    rk_nxt[95:64]  = lnk_i.rk[95:64] ^ rk_nxt[127:96];
    rk_nxt[63:32]  = lnk_i.rk[63:32] ^ rk_nxt[95:64];
    rk_nxt[31:0]   = lnk_i.rk[31:0] ^ rk_nxt[63:32];
  end

  always_comb begin
    lnk_nxt.vld = lnk_i.vld;
    lnk_nxt.rk  = rk_nxt;
    lnk_nxt.st  = mc ^ rk_nxt;
    lnk_nxt.key = lnk_i.key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk_r.vld <= 1'b0;
    end else if (adv) begin
      lnk_r.vld <= lnk_nxt.vld;
    end
    if (adv) begin
      lnk_r.st  <= lnk_nxt.st;
      lnk_r.rk  <= lnk_nxt.rk;
      lnk_r.key <= lnk_nxt.key;
    end
  end

endmodule

>>> rtl/aes128_key_trial_matcher_top.sv
// AES-128 key-trial matcher. Each input beat carries one candidate key; the
// block encrypts the fixed block held in cfg registers 0 (bytes 0..7) and 1
// (bytes 8..15) under that key and returns one output beat: the cipher text,
// the key echoed back and a hit flag for the expected byte pattern. A chain
// of ten round cells (round logic plus on-the-fly key expansion in each)
// takes a new key every cycle unless the result side stalls; a result passes
// the initial key add register, then the ten round registers. The whole chain advances
// only when the output stage is free, so a stall on the result side holds
// every beat in place and in_ready drops. Write the cfg registers only
// while no beat is in flight.
module aes128_key_trial_matcher_top
  import aktm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  aktm_stream_if.sink   in_ch,
  aktm_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  blk_t     blk_r;
  link_t    head_r;
  link_t    head_nxt;
  link_t    chain [NumRounds+1];
  in_beat_t in_beat;
  logic     adv;
  blk_t     ct;
  logic     hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBlockHigh: blk_r[127:64] <= cfg_data;
        RegBlockLow:  blk_r[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain moves when the last stage is empty or being drained.
  assign adv         = !chain[NumRounds].vld || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_beat     = in_beat_t'(in_ch.data);

  always_comb begin
    head_nxt.vld = in_ch.valid;
    head_nxt.key = {in_beat.key_high, in_beat.key_low};
    head_nxt.rk  = {in_beat.key_high, in_beat.key_low};
    head_nxt.st  = blk_r ^ {in_beat.key_high, in_beat.key_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (adv) begin
      head_r.vld <= head_nxt.vld;
    end
    if (adv) begin
      head_r.st  <= head_nxt.st;
      head_r.rk  <= head_nxt.rk;
      head_r.key <= head_nxt.key;
    end
  end

  assign chain[0] = head_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aktm_round_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .rnd   (4'(g)),
      .lnk_i (chain[g-1]),
      .lnk_r (chain[g])
    );
  end

  assign ct  = chain[NumRounds].st;
  assign hit = (byte_of(ct, 4) == 8'h00) && (byte_of(ct, 5) == 8'h00) &&
               (byte_of(ct, 10) == 8'h02) && (byte_of(ct, 11) == 8'h01) &&
               ((byte_of(ct, 3) == 8'h00) || (byte_of(ct, 3) == 8'h01) ||
                (byte_of(ct, 3) == 8'h02) || (byte_of(ct, 3) == 8'h15));

  out_beat_t ob;
  always_comb begin
    ob.hit            = hit;
    ob.tried_key_high = chain[NumRounds].key[127:64];
    ob.tried_key_low  = chain[NumRounds].key[63:0];
    ob.cipher_high    = ct[127:64];
    ob.cipher_low     = ct[63:0];
  end

  assign out_ch.valid = chain[NumRounds].vld;
  assign out_ch.data  = ob;

endmodule
